// File: design/alte_pkg.sv
// Shared types and constants for the array list table engine.
// Depends on nothing; alte_front, alte_back and the top level import it.
package alte_pkg;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 9;

    // Command codes as they arrive on the input item
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] write_data;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  used_count;
    } t_out;

    // Decoded operation class
    typedef enum logic [2:0] {
        OP_APPEND,
        OP_READ,
        OP_WRITE,
        OP_DELETE,
        OP_CLEAR,
        OP_BAD
    } t_op;

    // Classified command as queued between front and back
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  idx_next;
        logic [DATA_W-1:0] data;
    } t_cmd;

    // Back-end status seen by the top level
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage

// File: design/alte_fifo.sv
// Two-entry register queue of a given width.
// Depends on no package; used between front and back and on the result side.
module alte_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Store the incoming item
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= ~r_wp;
            end
            if (w_do_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// File: design/alte_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; holds the list entries.
module alte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then read through a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: design/alte_front.sv
// Front end: accepts input items, decodes the command and queues it.
// Depends on alte_pkg and alte_fifo.
module alte_front
    import alte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_item,
    output logic o_full,
    input  logic i_cmd_pop,
    output t_cmd o_cmd,
    output logic o_cmd_empty
);

    t_cmd w_cmd;

    // Classify the command and precompute the next index
    always_comb begin
        w_cmd          = '0;
        w_cmd.idx      = i_item.index;
        w_cmd.idx_next = {1'b0, i_item.index} + 9'd1;
        w_cmd.data     = i_item.write_data;
        case (i_item.command)
            CMD_APPEND: w_cmd.op = OP_APPEND;
            CMD_READ:   w_cmd.op = OP_READ;
            CMD_WRITE:  w_cmd.op = OP_WRITE;
            CMD_DELETE: w_cmd.op = OP_DELETE;
            CMD_CLEAR:  w_cmd.op = OP_CLEAR;
            default:    w_cmd.op = OP_BAD;
        endcase
    end

    // Queue decoded commands toward the back end
    alte_fifo #(
        .WIDTH($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

// File: design/alte_back.sv
// Back end: executes queued commands on the entry RAM and queues results.
// Depends on alte_pkg, alte_ram and alte_fifo.
module alte_back
    import alte_pkg::*;
#(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output t_out             o_result,
    output logic             o_empty,
    output t_stat            o_stat
);

    localparam int          AW      = $clog2(DEPTH);
    localparam logic [31:0] DEPTH_W = 32'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_SHIFT = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_cap;
    logic [CNT_W-1:0]         r_src, n_src;
    logic [IDX_W-1:0]         r_slot, n_slot;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [ELEMENT_WIDTH-1:0] w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [ELEMENT_WIDTH-1:0] w_rdata;
    logic                     w_res_push;
    logic                     w_res_full;
    t_out                     w_res;

    logic [CNT_W-1:0]         w_lim;
    logic                     w_in_range;
    logic [31:0]              w_cnt_ext;
    logic [31:0]              w_idx_ext;
    logic [31:0]              w_next_ext;
    logic [31:0]              w_src_dn_ext;
    logic [31:0]              w_src_up_ext;
    logic [CNT_W-1:0]         w_src_up;
    logic [63:0]              w_wdata_ext;
    logic [63:0]              w_rdata_ext;

    assign o_cfg_ready  = 1'b1;
    assign o_stat.busy  = (r_state != ST_IDLE);
    assign o_stat.count = r_count;

    // Effective limit saturates at the storage depth
    assign w_lim = (32'(r_cap) > DEPTH_W) ? DEPTH_W[CNT_W-1:0] : r_cap;
    assign w_in_range = (32'(i_cmd.idx) < 32'(r_count)) && (32'(i_cmd.idx) < DEPTH_W);

    // Address and data width adaptation
    assign w_src_up     = r_src + 9'd1;
    assign w_cnt_ext    = 32'(r_count);
    assign w_idx_ext    = 32'(i_cmd.idx);
    assign w_next_ext   = 32'(i_cmd.idx_next);
    assign w_src_dn_ext = 32'(r_src - 9'd1);
    assign w_src_up_ext = 32'(w_src_up);
    assign w_wdata_ext  = 64'(i_cmd.data);
    assign w_rdata_ext  = 64'(w_rdata);

    // Command sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_src      = r_src;
        n_slot     = r_slot;
        o_cmd_pop  = 1'b0;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_raddr    = '0;
        w_res_push = 1'b0;
        w_res      = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty && !w_res_full) begin
                    o_cmd_pop  = 1'b1;
                    n_slot     = i_cmd.idx;
                    w_res.slot = i_cmd.idx;
                    w_res_push = 1'b1;
                    case (i_cmd.op)
                        OP_APPEND: begin
                            if (r_count < w_lim) begin
                                w_we       = 1'b1;
                                w_waddr    = w_cnt_ext[AW-1:0];
                                w_wdata    = w_wdata_ext[ELEMENT_WIDTH-1:0];
                                w_res.ok   = 1'b1;
                                w_res.slot = r_count[IDX_W-1:0];
                                n_count    = r_count + 9'd1;
                            end
                        end
                        OP_READ: begin
                            if (w_in_range) begin
                                w_raddr    = w_idx_ext[AW-1:0];
                                w_res_push = 1'b0;
                                n_state    = ST_READ;
                            end
                        end
                        OP_WRITE: begin
                            if (w_in_range) begin
                                w_we     = 1'b1;
                                w_waddr  = w_idx_ext[AW-1:0];
                                w_wdata  = w_wdata_ext[ELEMENT_WIDTH-1:0];
                                w_res.ok = 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (w_in_range) begin
                                if (i_cmd.idx_next < r_count) begin
                                    // start the shift with the following entry
                                    w_raddr    = w_next_ext[AW-1:0];
                                    n_src      = i_cmd.idx_next;
                                    w_res_push = 1'b0;
                                    n_state    = ST_SHIFT;
                                end else begin
                                    w_res.ok = 1'b1;
                                    n_count  = r_count - 9'd1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            w_res.ok = 1'b1;
                            n_count  = '0;
                        end
                        default: begin
                            w_res.ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                w_res_push      = 1'b1;
                w_res.ok        = 1'b1;
                w_res.slot      = r_slot;
                w_res.read_data = w_rdata_ext[DATA_W-1:0];
                n_state         = ST_IDLE;
            end
            ST_SHIFT: begin
                // move the entry just read down by one place
                w_we    = 1'b1;
                w_waddr = w_src_dn_ext[AW-1:0];
                w_wdata = w_rdata;
                if (w_src_up < r_count) begin
                    w_raddr = w_src_up_ext[AW-1:0];
                    n_src   = w_src_up;
                end else begin
                    w_res_push = 1'b1;
                    w_res.ok   = 1'b1;
                    w_res.slot = r_slot;
                    n_count    = r_count - 9'd1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_res.used_count = n_count;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // Hold shift pointer and echoed index
    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_slot <= n_slot;
    end

    alte_ram #(
        .WIDTH(ELEMENT_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result queue toward the output side
    alte_fifo #(
        .WIDTH($bits(t_out))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

// File: design/array_list_table_engine_top.sv
// Array list table engine: dense list of entries with a used count.
// Push to result: command queue, back end, result queue; a read adds the registered RAM
// read in ST_READ, a delete before the last entry shifts later entries down in ST_SHIFT
// (one entry moved per cycle, RAM port). Throughput: one command per back-end pass.
// Synchronous active-low reset empties both queues, sets count to 0 and limit to 256.
// Depends on alte_pkg, alte_front and alte_back.
module array_list_table_engine_top
    import alte_pkg::*;
#(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  t_in              i_item,
    output logic             full,
    input  logic             pop,
    output t_out             o_result,
    output logic             empty,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    logic  w_cmd_empty;
    logic  w_cmd_pop;
    t_stat w_stat;

    alte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty)
    );

    alte_back #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .o_stat      (w_stat)
    );

`ifndef SYNTH
    // Reset empties the list
    a_reset_count: assert property (@(posedge i_clk)
        !i_rst_n |=> w_stat.count == '0)
        else $error("count not cleared by reset");

    // Count never exceeds the storage depth
    a_count_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_stat.count) <= 32'(DEPTH))
        else $error("count above depth");

    // Count moves by at most one, or drops to zero on clear
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (w_stat.count == $past(w_stat.count))
              || (w_stat.count == $past(w_stat.count) + 9'd1)
              || (w_stat.count == $past(w_stat.count) - 9'd1)
              || (w_stat.count == '0))
        else $error("count jumped");

    // Read or shift in progress implies a nonempty list
    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> w_stat.count != '0)
        else $error("busy on empty list");
`endif

endmodule
